// File: rtl/cpc_pkg.sv
// Shared types, constants and state codes for the convex polygon line clipper.
package cpc_pkg;

	localparam int MAX_EDGES_DEF   = 16;
	localparam int COORD_BITS_DEF  = 16;
	localparam int T_FRAC_BITS_DEF = 16;

	localparam int FIELD_W      = 16;
	localparam int EDGE_CNT_W   = 5;
	localparam logic [EDGE_CNT_W-1:0] EDGE_CNT_RST = 5'd4;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_CLIP  = 1'b1;

	localparam logic [1:0] SEL_START_X = 2'd0;
	localparam logic [1:0] SEL_START_Y = 2'd1;
	localparam logic [1:0] SEL_END_X   = 2'd2;
	localparam logic [1:0] SEL_END_Y   = 2'd3;

	typedef struct packed {
		logic               operation;
		logic [3:0]         vertex_index;
		logic signed [15:0] start_x;
		logic signed [15:0] start_y;
		logic signed [15:0] end_x;
		logic signed [15:0] end_y;
	} in_t;

	typedef struct packed {
		logic               visible;
		logic signed [15:0] clip_start_x;
		logic signed [15:0] clip_start_y;
		logic signed [15:0] clip_end_x;
		logic signed [15:0] clip_end_y;
	} out_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD_I,
		S_RD_J,
		S_DIFF,
		S_MUL,
		S_SUM,
		S_EVAL,
		S_DIV,
		S_DIV_FIN,
		S_LMUL,
		S_LADD,
		S_OUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       vwr;
		logic       load;
		logic       cap_vi;
		logic       diffs;
		logic       mul;
		logic       sum;
		logic       eval;
		logic       div_step;
		logic       div_fin;
		logic       lerp_mul;
		logic       lerp_add;
		logic [1:0] lerp_sel;
		logic       out_fire;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_div;
	} sts_t;

endpackage

// File: rtl/convex_polygon_line_clipper.sv
// Top level of the convex polygon line clipper: configuration register and unit wiring.
//
// Clips a segment against a stored clockwise convex polygon (Cyrus-Beck). A write item
// stores one vertex in the same cycle it is accepted and keeps the block free. A clip item
// keeps busy high while one shared unit walks the edges: each edge is read, differenced,
// multiplied, summed and tested, then passes through the bit-serial divider when its
// parameter needs it, and the four endpoint scalings follow before the result. The result
// shows for exactly one cycle with done high; the receiver cannot stall it, and the next
// item may be started in that same cycle. edge_count is written only while busy is low.
module convex_polygon_line_clipper import cpc_pkg::*; #(
	parameter int MAX_EDGES   = MAX_EDGES_DEF,
	parameter int COORD_BITS  = COORD_BITS_DEF,
	parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  in_t                   req,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [EDGE_CNT_W-1:0] cfg_data,
	output logic                  done,
	output out_t                  rsp
);

	localparam int EIW = $clog2(MAX_EDGES);
	localparam int NCW = $clog2(MAX_EDGES + 1);

	logic [EDGE_CNT_W-1:0] edge_count_q;
	logic [NCW-1:0]        n;
	cmd_t                  cmd;
	sts_t                  sts;
	logic [EIW-1:0]        rd_addr;

	// Edge count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_count_q <= EDGE_CNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			edge_count_q <= cfg_data;
		end
	end

	assign cfg_ready = !busy;

	// Edge count saturates at the store depth.
	always_comb begin
		if (32'(edge_count_q) > MAX_EDGES) begin
			n = NCW'(MAX_EDGES);
		end else begin
			n = NCW'(edge_count_q);
		end
	end

	cpc_ctrl #(
		.MAX_EDGES  (MAX_EDGES),
		.T_FRAC_BITS(T_FRAC_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.operation(req.operation),
		.n        (n),
		.sts      (sts),
		.cmd      (cmd),
		.rd_addr  (rd_addr),
		.busy     (busy),
		.done     (done)
	);

	cpc_dp #(
		.MAX_EDGES  (MAX_EDGES),
		.COORD_BITS (COORD_BITS),
		.T_FRAC_BITS(T_FRAC_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.rd_addr(rd_addr),
		.sts    (sts),
		.rsp    (rsp)
	);

	// A result is never shown twice in a row.
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held for more than one cycle");

	// A result appears only once the unit is free again.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result shown while busy");

	// An accepted clip item occupies the unit.
	a_clip_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (req.operation == OP_CLIP)) |=> busy)
		else $error("clip item did not start");

	// An invisible result carries zero endpoints.
	a_hidden_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rsp.visible) |-> ((rsp.clip_start_x == 0) && (rsp.clip_start_y == 0) &&
		(rsp.clip_end_x == 0) && (rsp.clip_end_y == 0)))
		else $error("hidden result with nonzero endpoints");

endmodule

// File: rtl/cpc_ctrl.sv
// Controller state machine: sequences vertex reads, edge tests, division and endpoint scaling.
module cpc_ctrl import cpc_pkg::*; #(
	parameter int MAX_EDGES   = MAX_EDGES_DEF,
	parameter int T_FRAC_BITS = T_FRAC_BITS_DEF,
	localparam int EIW = $clog2(MAX_EDGES),
	localparam int NCW = $clog2(MAX_EDGES + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           operation,
	input  logic [NCW-1:0] n,
	input  sts_t           sts,
	output cmd_t           cmd,
	output logic [EIW-1:0] rd_addr,
	output logic           busy,
	output logic           done
);

	localparam int CNW = $clog2(T_FRAC_BITS);

	state_t         state_q, state_d;
	logic [EIW-1:0] edge_q, edge_d;
	logic [CNW-1:0] cnt_q, cnt_d;
	logic [1:0]     sel_q, sel_d;
	logic           done_q;
	logic [NCW-1:0] edge_nxt;
	logic           last;
	logic           accept;

	assign busy     = (state_q != S_IDLE);
	assign done     = done_q;
	assign accept   = start && !busy;
	assign edge_nxt = NCW'(edge_q) + NCW'(1);
	assign last     = (edge_nxt == n);

	// State and counter registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			edge_q  <= '0;
			cnt_q   <= '0;
			sel_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			edge_q  <= edge_d;
			cnt_q   <= cnt_d;
			sel_q   <= sel_d;
			done_q  <= (state_q == S_OUT);
		end
	end

	// Next state and commands.
	always_comb begin
		state_d      = state_q;
		edge_d       = edge_q;
		cnt_d        = cnt_q;
		sel_d        = sel_q;
		cmd          = '0;
		cmd.lerp_sel = sel_q;
		rd_addr      = edge_q;
		case (state_q)
			S_IDLE: begin
				cmd.vwr = accept && (operation == OP_WRITE);
				if (accept && (operation == OP_CLIP)) begin
					cmd.load = 1'b1;
					edge_d   = '0;
					sel_d    = SEL_START_X;
					state_d  = (n == '0) ? S_LMUL : S_RD_I;
				end
			end
			S_RD_I: begin
				state_d = S_RD_J;
			end
			S_RD_J: begin
				rd_addr    = last ? '0 : edge_nxt[EIW-1:0];
				cmd.cap_vi = 1'b1;
				state_d    = S_DIFF;
			end
			S_DIFF: begin
				cmd.diffs = 1'b1;
				state_d   = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_SUM;
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				state_d = S_EVAL;
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				if (sts.need_div) begin
					cnt_d   = '0;
					state_d = S_DIV;
				end else if (last) begin
					state_d = S_LMUL;
				end else begin
					edge_d  = edge_nxt[EIW-1:0];
					state_d = S_RD_I;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + CNW'(1);
				if (cnt_q == CNW'(T_FRAC_BITS - 1)) begin
					state_d = S_DIV_FIN;
				end
			end
			S_DIV_FIN: begin
				cmd.div_fin = 1'b1;
				if (last) begin
					state_d = S_LMUL;
				end else begin
					edge_d  = edge_nxt[EIW-1:0];
					state_d = S_RD_I;
				end
			end
			S_LMUL: begin
				cmd.lerp_mul = 1'b1;
				state_d      = S_LADD;
			end
			S_LADD: begin
				cmd.lerp_add = 1'b1;
				sel_d        = sel_q + 2'd1;
				state_d      = (sel_q == SEL_END_Y) ? S_OUT : S_LMUL;
			end
			S_OUT: begin
				cmd.out_fire = 1'b1;
				state_d      = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/cpc_dp.sv
// Datapath: vertex store, edge products, bit-serial fraction divider and endpoint scaling.
module cpc_dp import cpc_pkg::*; #(
	parameter int MAX_EDGES   = MAX_EDGES_DEF,
	parameter int COORD_BITS  = COORD_BITS_DEF,
	parameter int T_FRAC_BITS = T_FRAC_BITS_DEF,
	localparam int EIW = $clog2(MAX_EDGES)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  in_t            req,
	input  cmd_t           cmd,
	input  logic [EIW-1:0] rd_addr,
	output sts_t           sts,
	output out_t           rsp
);

	localparam int CW  = COORD_BITS;
	localparam int DW  = CW + 1;
	localparam int PW  = 2 * CW + 2;
	localparam int NW  = 2 * CW + 3;
	localparam int TW  = T_FRAC_BITS + 1;
	localparam int LPW = CW + T_FRAC_BITS + 3;
	localparam logic [TW-1:0]  ONE  = TW'(1) << T_FRAC_BITS;
	localparam logic [LPW-1:0] HALF = LPW'(1) << (T_FRAC_BITS - 1);

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
	} vtx_t;

	vtx_t                  mem [MAX_EDGES];
	vtx_t                  rd_q;
	vtx_t                  vi_q;
	logic signed [CW-1:0]  ax_q, ay_q;
	logic signed [DW-1:0]  dx_q, dy_q;
	logic signed [DW-1:0]  px_q, py_q, nx_q, ny_q;
	logic signed [PW-1:0]  pa_q, pb_q, pc_q, pd_q;
	logic signed [NW-1:0]  num_q, den_q;
	logic [NW:0]           r_q;
	logic [NW-1:0]         d_q;
	logic [T_FRAC_BITS-1:0] q_q;
	logic                  entry_q;
	logic [TW-1:0]         tin_q, tout_q;
	logic                  ok_q;
	logic signed [LPW-1:0] lp_q;
	out_t                  res_q;
	out_t                  rsp_q;

	logic signed [CW-1:0]  wx, wy;
	logic                  entry, rej, go, eq, act;
	logic [NW-1:0]         un, ud;
	logic [NW:0]           r2;
	logic [TW-1:0]         cand;
	logic signed [DW-1:0]  ld;
	logic [TW-1:0]         lt;
	logic signed [LPW-1:0] la, lw, lsum;
	logic                  vis;

	// Input coordinates wrapped to the coordinate width.
	assign wx = CW'(req.start_x);
	assign wy = CW'(req.start_y);

	// Vertex store: one write port on accept, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.vwr && (32'(req.vertex_index) < MAX_EDGES)) begin
			mem[EIW'(req.vertex_index)] <= '{x: wx, y: wy};
		end
		rd_q <= mem[rd_addr];
	end

	// Edge test on the registered dot products.
	always_comb begin
		entry = (den_q < 0);
		un    = entry ? NW'(-num_q) : NW'(num_q);
		ud    = entry ? NW'(-den_q) : NW'(den_q);
		eq    = (un == ud);
		act   = 1'b0;
		rej   = 1'b0;
		go    = 1'b0;
		if (den_q == 0) begin
			rej = (num_q < 0);
		end else if (entry) begin
			act = (num_q <= 0);
			rej = act && (un > ud);
			go  = act && !rej;
		end else begin
			rej = (num_q < 0);
			go  = !rej && (num_q <= den_q);
		end
		sts.need_div = go && !eq;
	end

	assign r2   = {r_q[NW-1:0], 1'b0};
	assign cand = TW'(q_q) + TW'(r_q != '0);

	// Endpoint scaling operands.
	always_comb begin
		ld = ((cmd.lerp_sel == SEL_START_X) || (cmd.lerp_sel == SEL_END_X)) ? dx_q : dy_q;
		lt = ((cmd.lerp_sel == SEL_START_X) || (cmd.lerp_sel == SEL_START_Y)) ? tin_q : tout_q;
		la = ((cmd.lerp_sel == SEL_START_X) || (cmd.lerp_sel == SEL_END_X)) ?
			LPW'(ax_q) : LPW'(ay_q);
		lw   = lp_q + $signed(HALF);
		lsum = la + (lw >>> T_FRAC_BITS);
	end

	assign vis = ok_q && (tin_q < tout_q);

	// Segment, edge and parameter registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q   <= 1'b0;
			tin_q  <= '0;
			tout_q <= '0;
		end else begin
			if (cmd.load) begin
				ok_q   <= 1'b1;
				tin_q  <= '0;
				tout_q <= ONE;
			end
			if (cmd.eval) begin
				if (rej) begin
					ok_q <= 1'b0;
				end
				if (go && eq && entry) begin
					tin_q <= ONE;
				end
			end
			if (cmd.div_fin) begin
				if (entry_q) begin
					if (cand > tin_q) begin
						tin_q <= cand;
					end
				end else if (TW'(q_q) < tout_q) begin
					tout_q <= TW'(q_q);
				end
			end
		end
	end

	// Payload registers of the datapath.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ax_q <= wx;
			ay_q <= wy;
			dx_q <= DW'(CW'(req.end_x)) - DW'(wx);
			dy_q <= DW'(CW'(req.end_y)) - DW'(wy);
		end
		if (cmd.cap_vi) begin
			vi_q <= rd_q;
		end
		if (cmd.diffs) begin
			px_q <= DW'(vi_q.x) - DW'(ax_q);
			py_q <= DW'(vi_q.y) - DW'(ay_q);
			nx_q <= DW'(vi_q.y) - DW'(rd_q.y);
			ny_q <= DW'(rd_q.x) - DW'(vi_q.x);
		end
		if (cmd.mul) begin
			pa_q <= px_q * nx_q;
			pb_q <= py_q * ny_q;
			pc_q <= dx_q * nx_q;
			pd_q <= dy_q * ny_q;
		end
		if (cmd.sum) begin
			num_q <= NW'(pa_q) + NW'(pb_q);
			den_q <= NW'(pc_q) + NW'(pd_q);
		end
		// Restoring division, one quotient bit per cycle.
		if (cmd.eval) begin
			r_q     <= {1'b0, un};
			d_q     <= ud;
			q_q     <= '0;
			entry_q <= entry;
		end
		if (cmd.div_step) begin
			if (r2 >= {1'b0, d_q}) begin
				r_q <= r2 - {1'b0, d_q};
				q_q <= {q_q[T_FRAC_BITS-2:0], 1'b1};
			end else begin
				r_q <= r2;
				q_q <= {q_q[T_FRAC_BITS-2:0], 1'b0};
			end
		end
		if (cmd.lerp_mul) begin
			lp_q <= ld * $signed({1'b0, lt});
		end
		if (cmd.lerp_add) begin
			res_q.visible <= 1'b1;
			case (cmd.lerp_sel)
				SEL_START_X: res_q.clip_start_x <= lsum[FIELD_W-1:0];
				SEL_START_Y: res_q.clip_start_y <= lsum[FIELD_W-1:0];
				SEL_END_X:   res_q.clip_end_x   <= lsum[FIELD_W-1:0];
				SEL_END_Y:   res_q.clip_end_y   <= lsum[FIELD_W-1:0];
				default:     res_q.clip_end_y   <= lsum[FIELD_W-1:0];
			endcase
		end
		if (cmd.out_fire) begin
			rsp_q <= vis ? res_q : '0;
		end
	end

	assign rsp = rsp_q;

endmodule
